### rtl/core/trp_pkg.sv
package trp_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int LAYER_BITS    = 16;
    localparam int IDX_W         = 8;
    localparam int NS_W          = 32;
    localparam int BYTES_W       = 40;
    localparam int COUNT_W       = 32;
    localparam int TOTAL_W       = 48;
    localparam int Q16_W         = 17;
    localparam int WIN_W         = 16;
    localparam int NUM_W         = 52;
    localparam int DIV_W         = 54;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [Q16_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [19:0]      NS_PER_MS   = 20'd1000000;
    localparam logic [9:0]       SCORE_MAX   = 10'd1000;
    localparam logic [16:0]      RECIP_10    = 17'd52429;
    localparam logic [WIN_W-1:0] WINDOW_RST  = 16'd16;
    localparam logic [3:0]       EXP_N_LIMIT = 4'd12;

    typedef enum logic [1:0] {
        KIND_ACCESS  = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_EVICT   = 2'd2,
        KIND_QUERY   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PDIV,
        ST_CMUL,
        ST_CDGO,
        ST_CDIV,
        ST_PROB1,
        ST_PROB2,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_OUT
    } t_bstate;

    typedef struct packed {
        logic [COUNT_W-1:0]    count;
        logic [LAYER_BITS-1:0] last;
        logic                  reuse_known;
        logic [LAYER_BITS-1:0] reuse;
        logic [TOTAL_W-1:0]    total;
        logic                  seen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_kind                 kind;
        logic                  in_table;
        logic [IDX_W-1:0]      idx;
        logic [LAYER_BITS-1:0] layer;
        logic [NS_W-1:0]       ns;
        logic                  bytes_nz;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] a;
        logic [DIV_W-1:0] d;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [Q16_W-1:0] q;
    } t_div_rsp;

    typedef struct packed {
        logic                  entry_known;
        logic [LAYER_BITS-1:0] last;
        logic                  reuse_known;
        logic [LAYER_BITS-1:0] reuse;
        logic [LAYER_BITS:0]   next;
        logic [9:0]            score;
        logic [Q16_W-1:0]      cost;
        logic [Q16_W-1:0]      pressure;
    } t_result;

    function automatic logic [Q16_W-1:0] exp_int(input logic [3:0] n);
        logic [Q16_W-1:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [Q16_W-1:0] exp_tenth(input logic [3:0] k);
        logic [Q16_W-1:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd59299;
            4'd2:    v = 17'd53656;
            4'd3:    v = 17'd48550;
            4'd4:    v = 17'd43930;
            4'd5:    v = 17'd39750;
            4'd6:    v = 17'd35967;
            4'd7:    v = 17'd32544;
            4'd8:    v = 17'd29447;
            4'd9:    v = 17'd26645;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/trp_ram.sv
module trp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/trp_div.sv
module trp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trp_pkg::t_div_req i_req,
    output trp_pkg::t_div_rsp o_rsp
);

    logic [trp_pkg::DIV_W:0]   r_rem;
    logic [trp_pkg::DIV_W-1:0] r_den;
    logic [15:0]               r_q;
    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic                      r_sat;
    logic [trp_pkg::DIV_W:0]   w_shift;
    logic                      w_fit;

    // one quotient bit per cycle, restoring
    assign w_shift = {r_rem[trp_pkg::DIV_W-1:0], 1'b0};
    assign w_fit   = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.a};
            r_den <= i_req.d;
            r_q   <= '0;
            r_sat <= i_req.a >= i_req.d;
        end else if (r_busy) begin
            r_rem <= w_fit ? (w_shift - {1'b0, r_den}) : w_shift;
            r_q   <= {r_q[14:0], w_fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_sat ? trp_pkg::ONE_Q16 : {1'b0, r_q};

endmodule

### rtl/core/trp_front.sv
module trp_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [trp_pkg::IDX_W-1:0]      i_tensor_index,
    input  logic [trp_pkg::LAYER_BITS-1:0] i_layer,
    input  logic [trp_pkg::NS_W-1:0]       i_transfer_ns,
    input  logic [trp_pkg::BYTES_W-1:0]    i_byte_count,
    input  logic                           i_pop,
    output trp_pkg::t_head                 o_head
);

    trp_pkg::t_item              r_slot [trp_pkg::QUEUE_DEPTH];
    logic [trp_pkg::QPTR_W-1:0]  r_wp;
    logic [trp_pkg::QPTR_W-1:0]  r_rp;
    logic [trp_pkg::QPTR_W:0]    r_cnt;
    trp_pkg::t_item              w_new;
    logic                        w_push;

    // classify on entry
    always_comb begin
        w_new.kind     = trp_pkg::t_kind'(i_kind);
        w_new.in_table = 32'(i_tensor_index) < trp_pkg::TABLE_ENTRIES;
        w_new.idx      = i_tensor_index;
        w_new.layer    = i_layer;
        w_new.ns       = i_transfer_ns;
        w_new.bytes_nz = i_byte_count != '0;
    end

    assign o_in_ready = r_cnt != (trp_pkg::QPTR_W + 1)'(trp_pkg::QUEUE_DEPTH);
    assign w_push     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= w_new;
        end
    end

    assign o_head.valid = r_cnt != '0;
    assign o_head.item  = r_slot[r_rp];

endmodule

### rtl/core/trp_back.sv
module trp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  trp_pkg::t_head            i_head,
    output logic                      o_pop,
    input  logic [trp_pkg::WIN_W-1:0] i_window,
    output trp_pkg::t_div_req         o_div_req,
    input  trp_pkg::t_div_rsp         i_div_rsp,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output trp_pkg::t_result          o_res
);

    trp_pkg::t_bstate              r_state;
    trp_pkg::t_bstate              n_state;
    trp_pkg::t_item                r_item;
    logic [trp_pkg::WIN_W-1:0]     r_layers;
    logic [trp_pkg::WIN_W-1:0]     r_evicts;
    logic [trp_pkg::TABLE_ENTRIES-1:0] r_vld;
    trp_pkg::t_entry               r_ent;
    logic                          r_known;
    logic [trp_pkg::Q16_W-1:0]     r_pr;
    logic [trp_pkg::NUM_W-1:0]     r_num;
    logic [trp_pkg::Q16_W-1:0]     r_cost;
    logic                          r_nbig;
    logic [3:0]                    r_n;
    logic [3:0]                    r_k;
    logic [trp_pkg::Q16_W-1:0]     r_p;
    logic [33:0]                   r_s1;
    logic [50:0]                   r_s2;
    logic [9:0]                    r_score;
    logic                          r_out_vld;
    trp_pkg::t_result              r_res;

    logic                          w_we;
    logic                          w_load;
    logic [trp_pkg::ENTRY_W-1:0]   w_rdata;
    trp_pkg::t_entry               w_cur;
    trp_pkg::t_entry               w_upd;
    logic [trp_pkg::LAYER_BITS-1:0] w_d;
    logic [trp_pkg::LAYER_BITS:0]  w_sum;
    logic [trp_pkg::TOTAL_W:0]     w_tot;
    logic [32:0]                   w_recip;
    logic [13:0]                   w_n;
    logic [15:0]                   w_k;
    logic [33:0]                   w_pprod;
    logic [60:0]                   w_s3;
    logic [12:0]                   w_s3h;
    logic [trp_pkg::WIN_W-1:0]     w_linc;
    trp_pkg::t_result              w_res_next;

    trp_ram #(
        .WIDTH (trp_pkg::ENTRY_W),
        .DEPTH (trp_pkg::TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_item.idx[trp_pkg::TABLE_AW-1:0]),
        .i_wdata (w_upd),
        .i_raddr (i_head.item.idx[trp_pkg::TABLE_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            trp_pkg::ST_IDLE:  if (i_head.valid) n_state = trp_pkg::ST_READ;
            trp_pkg::ST_READ:  n_state = trp_pkg::ST_PDIV;
            trp_pkg::ST_PDIV:  if (i_div_rsp.done) n_state = trp_pkg::ST_CMUL;
            trp_pkg::ST_CMUL:  n_state = trp_pkg::ST_CDGO;
            trp_pkg::ST_CDGO:  n_state = trp_pkg::ST_CDIV;
            trp_pkg::ST_CDIV:  if (i_div_rsp.done) n_state = trp_pkg::ST_PROB1;
            trp_pkg::ST_PROB1: n_state = trp_pkg::ST_PROB2;
            trp_pkg::ST_PROB2: n_state = trp_pkg::ST_S1;
            trp_pkg::ST_S1:    n_state = trp_pkg::ST_S2;
            trp_pkg::ST_S2:    n_state = trp_pkg::ST_S3;
            trp_pkg::ST_S3:    n_state = trp_pkg::ST_OUT;
            trp_pkg::ST_OUT:   if (w_load) n_state = trp_pkg::ST_IDLE;
            default:           n_state = trp_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_load    = 1'b0;
        o_div_req = '0;
        case (r_state)
            trp_pkg::ST_IDLE: o_pop = i_head.valid;
            trp_pkg::ST_READ: begin
                w_we            = (r_item.kind == trp_pkg::KIND_ACCESS) && r_item.in_table;
                o_div_req.start = 1'b1;
                o_div_req.a     = trp_pkg::DIV_W'(r_evicts);
                o_div_req.d     = trp_pkg::DIV_W'(r_layers);
            end
            trp_pkg::ST_CDGO: begin
                o_div_req.start = 1'b1;
                o_div_req.a     = trp_pkg::DIV_W'(r_num);
                o_div_req.d     = trp_pkg::DIV_W'(r_num) + trp_pkg::DIV_W'(r_ent.total);
            end
            trp_pkg::ST_OUT: w_load = !r_out_vld || i_out_ready;
            default: ;
        endcase
    end

    // entry update for an access
    always_comb begin
        w_cur = r_vld[r_item.idx[trp_pkg::TABLE_AW-1:0]] ? trp_pkg::t_entry'(w_rdata) : '0;
        w_upd = w_cur;
        w_d   = r_item.layer - w_cur.last;
        w_sum = (trp_pkg::LAYER_BITS + 1)'(w_cur.reuse) + (trp_pkg::LAYER_BITS + 1)'(w_d);
        w_tot = (trp_pkg::TOTAL_W + 1)'(w_cur.total) + (trp_pkg::TOTAL_W + 1)'(r_item.ns);
        if (r_item.kind == trp_pkg::KIND_ACCESS && r_item.in_table) begin
            if (w_cur.count != '0) begin
                if (r_item.layer >= w_cur.last) begin
                    w_upd.reuse       = w_cur.reuse_known ? w_sum[trp_pkg::LAYER_BITS:1] : w_d;
                    w_upd.reuse_known = 1'b1;
                end else begin
                    w_upd.reuse       = '0;
                    w_upd.reuse_known = 1'b0;
                end
            end
            w_upd.last  = r_item.layer;
            w_upd.total = w_tot[trp_pkg::TOTAL_W] ? '1 : w_tot[trp_pkg::TOTAL_W-1:0];
            w_upd.seen  = w_cur.seen || r_item.bytes_nz;
            if (w_cur.count != '1) begin
                w_upd.count = w_cur.count + 1'b1;
            end
        end
    end

    // split reuse distance into tens and units, form probability and score products, step the window count
    always_comb begin
        w_recip = 33'(r_ent.reuse) * 33'(trp_pkg::RECIP_10);
        w_n     = w_recip[32:19];
        w_k     = r_ent.reuse - 16'({w_n, 3'b000}) - 16'({w_n, 1'b0});
        w_pprod = 34'(trp_pkg::exp_int(r_n)) * 34'(trp_pkg::exp_tenth(r_k)) + 34'd32768;
        w_s3    = 61'(r_s2) * 61'(trp_pkg::SCORE_MAX);
        w_s3h   = w_s3[60:48];
        w_linc  = (r_layers != '1) ? r_layers + 1'b1 : r_layers;
    end

    // assemble the result word
    always_comb begin
        w_res_next          = '0;
        w_res_next.pressure = r_pr;
        if (r_known) begin
            w_res_next.entry_known = 1'b1;
            w_res_next.last        = r_ent.last;
            w_res_next.cost        = r_cost;
            if (r_ent.reuse_known) begin
                w_res_next.reuse_known = 1'b1;
                w_res_next.reuse       = r_ent.reuse;
                w_res_next.next        = (trp_pkg::LAYER_BITS + 1)'(r_ent.last) +
                                         (trp_pkg::LAYER_BITS + 1)'(r_ent.reuse);
                w_res_next.score       = r_score;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= trp_pkg::ST_IDLE;
            r_layers  <= '0;
            r_evicts  <= '0;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                case (i_head.item.kind)
                    trp_pkg::KIND_ADVANCE: begin
                        if (w_linc >= i_window) begin
                            r_layers <= '0;
                            r_evicts <= '0;
                        end else begin
                            r_layers <= w_linc;
                        end
                    end
                    trp_pkg::KIND_EVICT: begin
                        if (r_evicts != '1) r_evicts <= r_evicts + 1'b1;
                    end
                    default: ;
                endcase
            end
            if (w_we) begin
                r_vld[r_item.idx[trp_pkg::TABLE_AW-1:0]] <= 1'b1;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            trp_pkg::ST_IDLE: r_item <= i_head.item;
            trp_pkg::ST_READ: begin
                r_ent   <= w_upd;
                r_known <= r_item.in_table && (w_upd.count != '0);
            end
            trp_pkg::ST_PDIV: begin
                if (i_div_rsp.done) r_pr <= (r_layers == '0) ? '0 : i_div_rsp.q;
            end
            trp_pkg::ST_CMUL: r_num <= trp_pkg::NUM_W'(r_ent.count) * trp_pkg::NUM_W'(trp_pkg::NS_PER_MS);
            trp_pkg::ST_CDIV: begin
                if (i_div_rsp.done) r_cost <= r_ent.seen ? i_div_rsp.q : trp_pkg::ONE_Q16;
            end
            trp_pkg::ST_PROB1: begin
                r_nbig <= w_n >= 14'(trp_pkg::EXP_N_LIMIT);
                r_n    <= w_n[3:0];
                r_k    <= w_k[3:0];
            end
            trp_pkg::ST_PROB2: r_p <= r_nbig ? '0 : w_pprod[32:16];
            trp_pkg::ST_S1:    r_s1 <= 34'(r_p) * 34'(r_cost);
            trp_pkg::ST_S2:    r_s2 <= 51'(r_s1) * 51'(trp_pkg::ONE_Q16 - r_pr);
            trp_pkg::ST_S3:    r_score <= (w_s3h > 13'(trp_pkg::SCORE_MAX)) ?
                                          trp_pkg::SCORE_MAX : w_s3h[9:0];
            trp_pkg::ST_OUT: begin
                if (w_load) r_res <= w_res_next;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_res       = r_res;

endmodule

### rtl/core/tensor_reuse_predictor_core.sv
// Channel   | Signals                                   | Direction | Handshake
// input     | i_kind .. i_byte_count (5 fields)         | in        | i_in_valid / o_in_ready
// result    | o_entry_known .. o_pressure (8 fields)    | out       | o_out_valid / i_out_ready
// config    | psel, penable, pwrite, paddr, pwdata      | in        | APB, pready tied high
//
// Every item passes through the back end in two passes of the shared 16-step
// serial divider (pressure, then cost factor) plus the table read and a short
// multiply chain. Reset is synchronous and active low; the table needs no
// clearing pass, a per-entry valid bit makes unwritten entries read as empty.
// The two-entry queue keeps taking items while the back end works; a waiting
// result holds the back end once the next result is ready, and then the queue
// fills and drops o_in_ready.
module tensor_reuse_predictor_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [trp_pkg::IDX_W-1:0]      i_tensor_index,
    input  logic [trp_pkg::LAYER_BITS-1:0] i_layer,
    input  logic [trp_pkg::NS_W-1:0]       i_transfer_ns,
    input  logic [trp_pkg::BYTES_W-1:0]    i_byte_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_entry_known,
    output logic [trp_pkg::LAYER_BITS-1:0] o_last_layer_out,
    output logic                           o_reuse_known,
    output logic [trp_pkg::LAYER_BITS-1:0] o_reuse_distance,
    output logic [trp_pkg::LAYER_BITS:0]   o_next_layer,
    output logic [9:0]                     o_score,
    output logic [trp_pkg::Q16_W-1:0]      o_cost_factor,
    output logic [trp_pkg::Q16_W-1:0]      o_pressure,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [trp_pkg::WIN_W-1:0] r_window;
    trp_pkg::t_head            w_head;
    logic                      w_pop;
    trp_pkg::t_div_req         w_div_req;
    trp_pkg::t_div_rsp         w_div_rsp;
    trp_pkg::t_result          w_res;

    // pressure window register, the only one, at any offset with paddr[2] clear
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_window) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= trp_pkg::WINDOW_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_window <= pwdata[trp_pkg::WIN_W-1:0];
        end
    end

    // front: accept, classify, queue
    trp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_tensor_index (i_tensor_index),
        .i_layer        (i_layer),
        .i_transfer_ns  (i_transfer_ns),
        .i_byte_count   (i_byte_count),
        .i_pop          (w_pop),
        .o_head         (w_head)
    );

    // shared serial divider for pressure and cost factor
    trp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // back: table update, prediction, result register
    trp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_window    (r_window),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_entry_known    = w_res.entry_known;
    assign o_last_layer_out = w_res.last;
    assign o_reuse_known    = w_res.reuse_known;
    assign o_reuse_distance = w_res.reuse;
    assign o_next_layer     = w_res.next;
    assign o_score          = w_res.score;
    assign o_cost_factor    = w_res.cost;
    assign o_pressure       = w_res.pressure;

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from empty queue");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_score_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_score != '0)) |-> (o_reuse_known && o_entry_known))
        else $error("score without known reuse");
`endif

endmodule

### bench/trp_checker.sv
module trp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [1:0]                     i_kind,
    input  logic [trp_pkg::IDX_W-1:0]      i_tensor_index,
    input  logic [trp_pkg::LAYER_BITS-1:0] i_layer,
    input  logic [trp_pkg::NS_W-1:0]       i_transfer_ns,
    input  logic [trp_pkg::BYTES_W-1:0]    i_byte_count,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_entry_known,
    input  logic [trp_pkg::LAYER_BITS-1:0] i_last_layer_out,
    input  logic                           i_reuse_known,
    input  logic [trp_pkg::LAYER_BITS-1:0] i_reuse_distance,
    input  logic [trp_pkg::LAYER_BITS:0]   i_next_layer,
    input  logic [9:0]                     i_score,
    input  logic [trp_pkg::Q16_W-1:0]      i_cost_factor,
    input  logic [trp_pkg::Q16_W-1:0]      i_pressure,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    output int                             o_pending,
    output int                             o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_WINDOW = 3'd0;

    localparam bit [16:0] EXP_WHOLE [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162,
                                             60, 22, 8, 3, 1};
    localparam bit [16:0] EXP_FRAC [10] = '{65536, 59299, 53656, 48550, 43930, 39750,
                                            35967, 32544, 29447, 26645};

    bit [31:0] hits     [256];
    bit [15:0] last_at  [256];
    bit [16:0] avg_dist [256];
    bit        dist_ok  [256];
    bit [47:0] ns_sum   [256];
    bit        moved    [256];
    bit [15:0] cur_layer, win_layers, win_evicts, window;

    trp_pkg::t_result expected_q[$];
    int               mismatches;

    function automatic bit [16:0] reuse_prob(input bit [16:0] d);
        bit [16:0] n, k;
        bit [63:0] p;
        n = d / 10;
        k = d % 10;
        if (n >= 12) return 0;
        p = (64'(EXP_WHOLE[n]) * EXP_FRAC[k] + 64'd32768) >> 16;
        return p[16:0];
    endfunction

    function automatic bit [16:0] cost_factor(input int i);
        bit [127:0] num, den;
        if (hits[i] == 0 || !moved[i]) return 17'h10000;
        num = 128'(hits[i]) * 128'd1000000;
        den = num + 128'(ns_sum[i]);
        num = (num << 16) / den;
        return num[16:0];
    endfunction

    // Update the table and window counters for one item, then form its answer.
    function automatic trp_pkg::t_result predict(input trp_pkg::t_kind kind, input int i,
                                                 input bit [15:0] layer, input bit [31:0] ns,
                                                 input bit [39:0] bytes);
        trp_pkg::t_result r;
        bit [16:0]        d, pr;
        bit [63:0]        q;
        bit [127:0]       s;
        case (kind)
            trp_pkg::KIND_ACCESS: begin
                if (hits[i] > 0) begin
                    if (layer >= last_at[i]) begin
                        d = 17'(layer - last_at[i]);
                        avg_dist[i] = dist_ok[i] ? (avg_dist[i] + d) >> 1 : d;
                        dist_ok[i] = 1;
                    end else begin
                        // stepping backward loses the reuse history
                        avg_dist[i] = 0;
                        dist_ok[i] = 0;
                    end
                end
                last_at[i] = layer;
                ns_sum[i] = (48'hFFFF_FFFF_FFFF - ns_sum[i] < ns) ? 48'hFFFF_FFFF_FFFF
                                                                    : ns_sum[i] + ns;
                if (bytes != 0) moved[i] = 1;
                if (hits[i] != 32'hFFFF_FFFF) hits[i]++;
            end
            trp_pkg::KIND_ADVANCE: begin
                cur_layer = layer;
                if (win_layers != 16'hFFFF) win_layers++;
                if (win_layers >= window) begin
                    win_layers = 0;
                    win_evicts = 0;
                end
            end
            trp_pkg::KIND_EVICT: begin
                if (win_evicts != 16'hFFFF) win_evicts++;
            end
            default: ;
        endcase

        if (win_layers == 0) pr = 0;
        else begin
            q = (64'(win_evicts) << 16) / win_layers;
            pr = (q > 64'h10000) ? 17'h10000 : q[16:0];
        end

        r = '0;
        r.pressure = pr;
        if (hits[i] > 0) begin
            r.entry_known = 1;
            r.last = last_at[i];
            r.cost = cost_factor(i);
            if (dist_ok[i]) begin
                s = 128'(reuse_prob(avg_dist[i])) * r.cost;
                s = (s * (128'h10000 - pr) * 128'd1000) >> 48;
                if (s > 1000) s = 1000;
                r.reuse_known = 1;
                r.reuse = avg_dist[i][15:0];
                r.next = 17'(last_at[i]) + avg_dist[i];
                r.score = s[9:0];
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        trp_pkg::t_result want;
        if (!i_rst_n) begin
            foreach (hits[j]) begin
                hits[j] = 0; last_at[j] = 0; avg_dist[j] = 0;
                dist_ok[j] = 0; ns_sum[j] = 0; moved[j] = 0;
            end
            cur_layer = 0; win_layers = 0; win_evicts = 0;
            window = 16'd16;
            expected_q.delete();
        end else begin
            // register write lands on the access cycle
            if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW)
                window = pwdata[15:0];
            if (i_in_valid && i_in_ready)
                expected_q.insert(expected_q.size(),
                                  predict(trp_pkg::t_kind'(i_kind), int'(i_tensor_index),
                                          i_layer, i_transfer_ns, i_byte_count));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("entry_known", want.entry_known, i_entry_known);
                    compare_field("last_layer_out", want.last, i_last_layer_out);
                    compare_field("reuse_known", want.reuse_known, i_reuse_known);
                    compare_field("reuse_distance", want.reuse, i_reuse_distance);
                    compare_field("next_layer", want.next, i_next_layer);
                    compare_field("score", want.score, i_score);
                    compare_field("cost_factor", want.cost, i_cost_factor);
                    compare_field("pressure", want.pressure, i_pressure);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatches;
    end

    initial mismatches = 0;

endmodule

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_WINDOW = 3'd0;

    logic                           i_clk = 0;
    logic                           i_rst_n = 0;
    logic                           in_valid = 0;
    logic                           in_ready;
    logic [1:0]                     kind = trp_pkg::KIND_QUERY;
    logic [trp_pkg::IDX_W-1:0]      tensor_index = 0;
    logic [trp_pkg::LAYER_BITS-1:0] layer = 0;
    logic [trp_pkg::NS_W-1:0]       transfer_ns = 0;
    logic [trp_pkg::BYTES_W-1:0]    byte_count = 0;
    logic                           out_valid;
    logic                           out_ready = 0;
    logic                           entry_known, reuse_known;
    logic [trp_pkg::LAYER_BITS-1:0] last_layer_out, reuse_distance;
    logic [trp_pkg::LAYER_BITS:0]   next_layer;
    logic [9:0]                     score;
    logic [trp_pkg::Q16_W-1:0]      cost_factor, pressure;
    logic                           psel = 0, penable = 0, pwrite = 0;
    logic [2:0]                     paddr = 0;
    logic [31:0]                    pwdata = 0, prdata;
    logic                           pready;
    int                             pending, mismatches;

    // sender and receiver idle odds, in percent
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold_req = 0;
    // running layer used to build forward-moving access sequences
    bit [15:0] walk_layer = 0;

    always #10 i_clk = ~i_clk;

    tensor_reuse_predictor_core i_dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_kind(kind), .i_tensor_index(tensor_index), .i_layer(layer),
        .i_transfer_ns(transfer_ns), .i_byte_count(byte_count),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_entry_known(entry_known), .o_last_layer_out(last_layer_out),
        .o_reuse_known(reuse_known), .o_reuse_distance(reuse_distance),
        .o_next_layer(next_layer), .o_score(score),
        .o_cost_factor(cost_factor), .o_pressure(pressure),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    trp_checker i_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_kind(kind), .i_tensor_index(tensor_index), .i_layer(layer),
        .i_transfer_ns(transfer_ns), .i_byte_count(byte_count),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_entry_known(entry_known), .i_last_layer_out(last_layer_out),
        .i_reuse_known(reuse_known), .i_reuse_distance(reuse_distance),
        .i_next_layer(next_layer), .i_score(score),
        .i_cost_factor(cost_factor), .i_pressure(pressure),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_pending(pending), .o_mismatches(mismatches)
    );

    // Receiver: random back-pressure, or a long hold-off when asked for one.
    initial begin
        int held;
        forever begin
            @(negedge i_clk);
            if (recv_hold_req) begin
                recv_hold_req = 0;
                out_ready <= 0;
                // hold while the sender keeps offering transfers
                for (held = 1; held < 400; held++) @(negedge i_clk);
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one transfer; idle first at random, then hold valid until taken.
    task automatic send(input trp_pkg::t_kind k, input bit [7:0] idx, input bit [15:0] lyr,
                        input bit [31:0] ns, input bit [39:0] bytes);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge i_clk);
        end
        in_valid     <= 1;
        kind         <= k;
        tensor_index <= idx;
        layer        <= lyr;
        transfer_ns  <= ns;
        byte_count   <= bytes;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Drain every expected result, then give the back end time to settle.
    task automatic drain;
        @(negedge i_clk);
        in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_window(input bit [15:0] value);
        drain();
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_WINDOW; pwdata <= {16'h0, value};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Random item of any kind, mostly on a few hot tensors with forward layers, plus noise.
    task automatic send_random;
        bit [7:0]  idx;
        bit [15:0] lyr;
        bit [31:0] ns;
        bit [39:0] bytes;
        int        pick;
        idx   = ($urandom_range(9) < 8) ? 8'($urandom_range(15)) : 8'($urandom);
        pick  = $urandom_range(99);
        ns    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3000000);
        bytes = ($urandom_range(9) == 0) ? 40'd0 : {8'($urandom), 32'($urandom)};
        if (pick < 8) lyr = 16'($urandom);
        else if (pick < 14) lyr = walk_layer - 16'($urandom_range(1, 20));
        else begin
            walk_layer = walk_layer + 16'($urandom_range(30));
            lyr = walk_layer;
        end
        pick = $urandom_range(99);
        if (pick < 45) send(trp_pkg::KIND_ACCESS, idx, lyr, ns, bytes);
        else if (pick < 65) send(trp_pkg::KIND_ADVANCE, idx, lyr, ns, bytes);
        else if (pick < 80) send(trp_pkg::KIND_EVICT, idx, lyr, ns, bytes);
        else send(trp_pkg::KIND_QUERY, idx, lyr, ns, bytes);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: empty entry, zero-byte access, forward then backward layers,
        // field extremes, large distances, and window pressure.
        send_idle_pct = 28;
        recv_idle_pct = 86;
        send(trp_pkg::KIND_QUERY, 8'd0, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_EVICT, 8'd0, 16'd0, 32'd0, 40'd0);
        write_window(16'd3);
        send(trp_pkg::KIND_ACCESS, 8'd0, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_ACCESS, 8'd0, 16'd5, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        send(trp_pkg::KIND_ACCESS, 8'd0, 16'd17, 32'd1000000, 40'd1);
        send(trp_pkg::KIND_ACCESS, 8'd0, 16'd3, 32'd5, 40'd7);
        send(trp_pkg::KIND_ACCESS, 8'd0, 16'd3, 32'd5, 40'd7);
        send(trp_pkg::KIND_ACCESS, 8'd0, 16'hFFFF, 32'd0, 40'd0);
        send(trp_pkg::KIND_ACCESS, 8'd0, 16'hFFFF, 32'd0, 40'd0);
        send(trp_pkg::KIND_QUERY, 8'd0, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_ACCESS, 8'd255, 16'd0, 32'hFFFF_FFFF, 40'd1);
        send(trp_pkg::KIND_ACCESS, 8'd255, 16'd200, 32'd0, 40'd0);
        send(trp_pkg::KIND_ACCESS, 8'd255, 16'd209, 32'd0, 40'd0);
        send(trp_pkg::KIND_EVICT, 8'd255, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_EVICT, 8'd255, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_ADVANCE, 8'd255, 16'hFFFF, 32'd0, 40'd0);
        send(trp_pkg::KIND_EVICT, 8'd255, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_EVICT, 8'd255, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_QUERY, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        send(trp_pkg::KIND_ADVANCE, 8'd1, 16'd0, 32'd0, 40'd0);
        send(trp_pkg::KIND_ADVANCE, 8'd1, 16'd1, 32'd0, 40'd0);
        send(trp_pkg::KIND_QUERY, 8'd1, 16'd0, 32'd0, 40'd0);

        // Phase 1: window of one, slow receiver, one long receiver hold-off.
        write_window(16'd1);
        for (int n = 0; n < 500; n++) begin
            if (n == 100) recv_hold_req = 1;
            if (n == 300) drain();
            send_random();
        end

        // Phase 2: largest window, slow sender.
        send_idle_pct = 86;
        recv_idle_pct = 28;
        write_window(16'hFFFF);
        for (int n = 0; n < 500; n++) send_random();

        // Phase 3: no idling; zero window, then a modest random one.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_window(16'd0);
        for (int n = 0; n < 500; n++) send_random();
        write_window(16'($urandom_range(2, 40)));
        for (int n = 0; n < 500; n++) send_random();

        drain();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #100ms;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/core/trp_pkg.sv
rtl/core/trp_ram.sv
rtl/core/trp_div.sv
rtl/core/trp_front.sv
rtl/core/trp_back.sv
rtl/core/tensor_reuse_predictor_core.sv
bench/trp_checker.sv
bench/tb_top.sv
